// ===== hw/rtl/fotb_pkg.sv =====
`default_nettype none
package fotb_pkg;

	localparam int DivBits = 64;
	localparam int IdxBits = 32;
	localparam int TierStages = 4;

	localparam logic [2:0] TIER_DIRECT = 3'd0;
	localparam logic [2:0] TIER_SINGLE = 3'd1;
	localparam logic [2:0] TIER_DOUBLE = 3'd2;
	localparam logic [2:0] TIER_TRIPLE = 3'd3;
	localparam logic [2:0] TIER_PAST   = 3'd4;

	localparam logic [2:0] REG_BLOCK_SIZE  = 3'd0;
	localparam logic [2:0] REG_DIRECT_SPAN = 3'd1;
	localparam logic [2:0] REG_SINGLE_SPAN = 3'd2;
	localparam logic [2:0] REG_DOUBLE_SPAN = 3'd3;
	localparam logic [2:0] REG_TRIPLE_SPAN = 3'd4;

	typedef struct packed {
		logic [2:0]         tier;
		logic [IdxBits-1:0] top;
		logic [IdxBits-1:0] mid;
		logic               ovf;
	} side_t;

	function automatic logic [IdxBits-1:0] sat_idx(input logic [DivBits-1:0] v);
		sat_idx = (|v[DivBits-1:IdxBits]) ? {IdxBits{1'b1}} : v[IdxBits-1:0];
	endfunction

	function automatic logic idx_over(input logic [DivBits-1:0] v);
		idx_over = |v[DivBits-1:IdxBits];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/file_offset_to_block_tier_index.sv =====
// Maps a 64-bit file byte offset onto its block tier (direct, single,
// double or triple indirect, or past the limit) and the pointer table
// index at each level.
// Input channel: in_valid, in_ready, byte_offset. Output channel:
// out_valid, out_ready, tier, top_index, mid_index, leaf_index and
// index_overflow. Configuration channel: cfg_valid, cfg_ready (always
// high), cfg_index and cfg_data; write it only while no word is in flight.
// A word passes from acceptance to output through four tier stages,
// three bit-serial pipelined dividers of 64 stages each (top, mid, leaf
// level), and the output register. One word is accepted every cycle
// unless the receiver stalls with a word in the output register; then the
// whole pipeline holds and in_ready drops; nothing is lost or repeated.
// Reset empties the pipeline and loads the default block size and spans.
`default_nettype none
module file_offset_to_block_tier_index (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] byte_offset,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       tier,
	output logic [31:0]      top_index,
	output logic [31:0]      mid_index,
	output logic [31:0]      leaf_index,
	output logic             index_overflow,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [16:0] block_size_q;
	logic [63:0] direct_span_q;
	logic [63:0] single_span_q;
	logic [63:0] double_span_q;
	logic [63:0] triple_span_q;
	logic [63:0] bs;
	logic        en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= 17'd4096;
			direct_span_q <= 64'd49152;
			single_span_q <= 64'd2097152;
			double_span_q <= 64'd1073741824;
			triple_span_q <= 64'd549755813888;
		end else if (cfg_valid) begin
			case (cfg_index)
				fotb_pkg::REG_BLOCK_SIZE:  block_size_q  <= cfg_data[16:0];
				fotb_pkg::REG_DIRECT_SPAN: direct_span_q <= cfg_data;
				fotb_pkg::REG_SINGLE_SPAN: single_span_q <= cfg_data;
				fotb_pkg::REG_DOUBLE_SPAN: double_span_q <= cfg_data;
				fotb_pkg::REG_TRIPLE_SPAN: triple_span_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bs = (block_size_q == '0) ? 64'd1 : {47'd0, block_size_q};

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic        c_valid;
	logic [2:0]  c_tier;
	logic [63:0] c_rem;

	fotb_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (in_valid),
		.in_offset   (byte_offset),
		.direct_span (direct_span_q),
		.single_span (single_span_q),
		.double_span (double_span_q),
		.triple_span (triple_span_q),
		.out_valid   (c_valid),
		.out_tier    (c_tier),
		.out_rem     (c_rem)
	);

	fotb_pkg::side_t side_a;
	logic            a_valid;
	logic [63:0]     a_q;
	logic [63:0]     a_r;
	fotb_pkg::side_t a_side;

	assign side_a.tier = c_tier;
	assign side_a.top  = '0;
	assign side_a.mid  = '0;
	assign side_a.ovf  = 1'b0;

	fotb_div u_div_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c_valid),
		.in_use    (c_tier == fotb_pkg::TIER_TRIPLE),
		.in_num    (c_rem),
		.in_side   (side_a),
		.divisor   (double_span_q),
		.out_valid (a_valid),
		.out_q     (a_q),
		.out_r     (a_r),
		.out_side  (a_side)
	);

	fotb_pkg::side_t side_b;
	logic            b_valid;
	logic [63:0]     b_q;
	logic [63:0]     b_r;
	fotb_pkg::side_t b_side;
	logic            a_use;

	assign a_use       = a_side.tier == fotb_pkg::TIER_TRIPLE;
	assign side_b.tier = a_side.tier;
	assign side_b.top  = a_use ? fotb_pkg::sat_idx(a_q) : '0;
	assign side_b.mid  = '0;
	assign side_b.ovf  = a_use && fotb_pkg::idx_over(a_q);

	fotb_div u_div_mid (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (a_valid),
		.in_use    (a_side.tier == fotb_pkg::TIER_DOUBLE || a_use),
		.in_num    (a_r),
		.in_side   (side_b),
		.divisor   (single_span_q),
		.out_valid (b_valid),
		.out_q     (b_q),
		.out_r     (b_r),
		.out_side  (b_side)
	);

	fotb_pkg::side_t side_c;
	logic            l_valid;
	logic [63:0]     l_q;
	logic [63:0]     l_r;
	fotb_pkg::side_t l_side;
	logic            b_use;
	logic            l_use;

	assign b_use       = b_side.tier == fotb_pkg::TIER_DOUBLE ||
		b_side.tier == fotb_pkg::TIER_TRIPLE;
	assign side_c.tier = b_side.tier;
	assign side_c.top  = b_side.top;
	assign side_c.mid  = b_use ? fotb_pkg::sat_idx(b_q) : '0;
	assign side_c.ovf  = b_side.ovf || (b_use && fotb_pkg::idx_over(b_q));

	fotb_div u_div_leaf (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (b_valid),
		.in_use    (b_side.tier != fotb_pkg::TIER_PAST),
		.in_num    (b_r),
		.in_side   (side_c),
		.divisor   (bs),
		.out_valid (l_valid),
		.out_q     (l_q),
		.out_r     (l_r),
		.out_side  (l_side)
	);

	logic        out_valid_q;
	logic [2:0]  tier_q;
	logic [31:0] top_q;
	logic [31:0] mid_q;
	logic [31:0] leaf_q;
	logic        ovf_q;

	assign l_use = l_side.tier != fotb_pkg::TIER_PAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= l_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tier_q <= l_side.tier;
			top_q  <= l_side.top;
			mid_q  <= l_side.mid;
			leaf_q <= l_use ? fotb_pkg::sat_idx(l_q) : '0;
			ovf_q  <= l_side.ovf || (l_use && fotb_pkg::idx_over(l_q));
		end
	end

	assign out_valid      = out_valid_q;
	assign tier           = tier_q;
	assign top_index      = top_q;
	assign mid_index      = mid_q;
	assign leaf_index     = leaf_q;
	assign index_overflow = ovf_q;

	// The leaf remainder is only a by-product of the last divider.
	logic unused_r;
	assign unused_r = ^l_r;

	a_past_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tier == fotb_pkg::TIER_PAST |->
			top_index == '0 && mid_index == '0 && leaf_index == '0 && !index_overflow)
		else $error("past-limit word carries nonzero indices");

	a_low_tier_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (tier == fotb_pkg::TIER_DIRECT || tier == fotb_pkg::TIER_SINGLE) |->
			top_index == '0 && mid_index == '0)
		else $error("direct or single tier word carries upper indices");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && index_overflow |->
			top_index == '1 || mid_index == '1 || leaf_index == '1)
		else $error("overflow flagged without a saturated index");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while the output stalls");

endmodule
`default_nettype wire

// ===== hw/rtl/fotb_classify.sv =====
`default_nettype none
module fotb_classify (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [63:0] in_offset,
	input  wire logic [63:0] direct_span,
	input  wire logic [63:0] single_span,
	input  wire logic [63:0] double_span,
	input  wire logic [63:0] triple_span,
	output logic             out_valid,
	output logic [2:0]       out_tier,
	output logic [63:0]      out_rem
);

	logic [63:0] span [0:fotb_pkg::TierStages-1];
	logic        v_s    [0:fotb_pkg::TierStages];
	logic        done_s [0:fotb_pkg::TierStages];
	logic [2:0]  tier_s [0:fotb_pkg::TierStages];
	logic [63:0] x_s    [0:fotb_pkg::TierStages];

	assign span[0] = direct_span;
	assign span[1] = single_span;
	assign span[2] = double_span;
	assign span[3] = triple_span;

	assign v_s[0]    = in_valid;
	assign done_s[0] = 1'b0;
	assign tier_s[0] = fotb_pkg::TIER_PAST;
	assign x_s[0]    = in_offset;

	// Each stage peels off one tier: one subtract and compare per stage.
	for (genvar k = 0; k < fotb_pkg::TierStages; k++) begin : g_stage
		logic hit;
		assign hit = !done_s[k] && (x_s[k] < span[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				done_s[k+1] <= done_s[k] || hit;
				tier_s[k+1] <= hit ? 3'(k) : tier_s[k];
				x_s[k+1]    <= (done_s[k] || hit) ? x_s[k] : x_s[k] - span[k];
			end
		end
	end

	assign out_valid = v_s[fotb_pkg::TierStages];
	assign out_tier  = tier_s[fotb_pkg::TierStages];
	assign out_rem   = x_s[fotb_pkg::TierStages];

endmodule
`default_nettype wire

// ===== hw/rtl/fotb_div.sv =====
`default_nettype none
module fotb_div (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire logic            in_use,
	input  wire logic [63:0]     in_num,
	input  wire fotb_pkg::side_t in_side,
	input  wire logic [63:0]     divisor,
	output logic                 out_valid,
	output logic [63:0]          out_q,
	output logic [63:0]          out_r,
	output fotb_pkg::side_t      out_side
);

	localparam int N = fotb_pkg::DivBits;

	logic            v_s    [0:N];
	logic            use_s  [0:N];
	logic [N-1:0]    nq_s   [0:N];
	logic [N-1:0]    r_s    [0:N];
	fotb_pkg::side_t side_s [0:N];

	assign v_s[0]    = in_valid;
	assign use_s[0]  = in_use;
	assign nq_s[0]   = in_num;
	assign r_s[0]    = '0;
	assign side_s[0] = in_side;

	// One quotient bit per stage. An unused stage divides by zero, which
	// gives all ones as quotient and the dividend as remainder.
	for (genvar k = 0; k < N; k++) begin : g_step
		logic [N-1:0] dd;
		logic [N:0]   trial;
		logic         ge;
		logic [N:0]   diff;

		assign dd    = use_s[k] ? divisor : '0;
		assign trial = {r_s[k], nq_s[k][N-1]};
		assign ge    = trial >= {1'b0, dd};
		assign diff  = trial - {1'b0, dd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				use_s[k+1]  <= use_s[k];
				nq_s[k+1]   <= {nq_s[k][N-2:0], ge};
				r_s[k+1]    <= ge ? diff[N-1:0] : trial[N-1:0];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[N];
	assign out_q     = nq_s[N];
	assign out_r     = r_s[N];
	assign out_side  = side_s[N];

endmodule
`default_nettype wire

// ===== bench/tb_file_offset_to_block_tier_index.sv =====
`timescale 1ns / 100ps

typedef struct {
	logic [2:0]  tier;
	logic [31:0] top;
	logic [31:0] mid;
	logic [31:0] leaf;
	logic        ovf;
} tier_map_t;

class tier_map_board;
	logic [16:0] blk_size = 17'd4096;
	logic [63:0] span_direct = 64'd49152;
	logic [63:0] span_single = 64'd2097152;
	logic [63:0] span_double = 64'd1073741824;
	logic [63:0] span_triple = 64'd549755813888;
	tier_map_t pending_maps[$];
	int errors = 0;

	function void set_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			fotb_pkg::REG_BLOCK_SIZE: blk_size = val[16:0];
			fotb_pkg::REG_DIRECT_SPAN: span_direct = val;
			fotb_pkg::REG_SINGLE_SPAN: span_single = val;
			fotb_pkg::REG_DOUBLE_SPAN: span_double = val;
			fotb_pkg::REG_TRIPLE_SPAN: span_triple = val;
			default: ;
		endcase
	endfunction

	function logic [63:0] quot(logic [63:0] a, logic [63:0] b);
		return (b == 0) ? '1 : a / b;
	endfunction

	function logic [63:0] remd(logic [63:0] a, logic [63:0] b);
		return (b == 0) ? a : a % b;
	endfunction

	function logic [31:0] clip(logic [63:0] v, inout logic ovf);
		if (v[63:32] != 0) begin
			ovf = 1'b1;
			return '1;
		end
		return v[31:0];
	endfunction

	function void note_offset(logic [63:0] off);
		tier_map_t m;
		logic [63:0] bs, rem, r2;
		bs = (blk_size == 0) ? 64'd1 : {47'd0, blk_size};
		m = '{fotb_pkg::TIER_PAST, 32'd0, 32'd0, 32'd0, 1'b0};
		if (off < span_direct) begin
			m.tier = fotb_pkg::TIER_DIRECT;
			m.leaf = clip(off / bs, m.ovf);
		end else begin
			rem = off - span_direct;
			if (rem < span_single) begin
				m.tier = fotb_pkg::TIER_SINGLE;
				m.leaf = clip(rem / bs, m.ovf);
			end else begin
				rem = rem - span_single;
				if (rem < span_double) begin
					m.tier = fotb_pkg::TIER_DOUBLE;
					m.mid = clip(quot(rem, span_single), m.ovf);
					m.leaf = clip(remd(rem, span_single) / bs, m.ovf);
				end else begin
					rem = rem - span_double;
					if (rem < span_triple) begin
						m.tier = fotb_pkg::TIER_TRIPLE;
						m.top = clip(quot(rem, span_double), m.ovf);
						r2 = remd(rem, span_double);
						m.mid = clip(quot(r2, span_single), m.ovf);
						m.leaf = clip(remd(r2, span_single) / bs, m.ovf);
					end
				end
			end
		end
		pending_maps.push_back(m);
	endfunction

	function void check_map(tier_map_t got);
		tier_map_t exp;
		if (pending_maps.size() == 0) begin
			$display("%0t: unexpected word tier=%0d", $time, got.tier);
			errors++;
			return;
		end
		exp = pending_maps.pop_front();
		if (got.tier !== exp.tier) begin
			$display("%0t: tier exp %0d got %0d", $time, exp.tier, got.tier);
			errors++;
		end
		if (got.top !== exp.top) begin
			$display("%0t: top_index exp %h got %h", $time, exp.top, got.top);
			errors++;
		end
		if (got.mid !== exp.mid) begin
			$display("%0t: mid_index exp %h got %h", $time, exp.mid, got.mid);
			errors++;
		end
		if (got.leaf !== exp.leaf) begin
			$display("%0t: leaf_index exp %h got %h", $time, exp.leaf, got.leaf);
			errors++;
		end
		if (got.ovf !== exp.ovf) begin
			$display("%0t: index_overflow exp %b got %b", $time, exp.ovf, got.ovf);
			errors++;
		end
	endfunction
endclass

module tb_file_offset_to_block_tier_index;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [63:0] byte_offset = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [2:0] tier;
	logic [31:0] top_index, mid_index, leaf_index;
	logic index_overflow;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [63:0] cfg_data = 0;
	logic sink_on = 0;
	tier_map_board board;

	file_offset_to_block_tier_index uut (.*);

	always #1 clk = ~clk;

	function int gap_len();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
		return 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_map('{tier, top_index, mid_index, leaf_index, index_overflow});
	end

	initial begin
		int g;
		forever begin
			@(negedge clk);
			if (!sink_on) begin
				out_ready <= 1'b1;
			end else begin
				g = gap_len();
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	task automatic send_offset(logic [63:0] off);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		byte_offset <= off;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_offset(off);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_maps.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function logic [63:0] pick_offset();
		logic [63:0] b;
		case ($urandom_range(0, 5))
			0: return rand64();
			1: return rand64() >> $urandom_range(0, 63);
			2: begin
				b = board.span_direct + board.span_single;
				return b + 64'($urandom_range(0, 8)) - 64'd4;
			end
			3: begin
				b = board.span_direct + board.span_single + board.span_double;
				return b + (rand64() >> $urandom_range(10, 63));
			end
			4: return board.span_direct + 64'($urandom_range(0, 8)) - 64'd4;
			default: return rand64() >> $urandom_range(20, 50);
		endcase
	endfunction

	task automatic random_config();
		write_reg(fotb_pkg::REG_BLOCK_SIZE, $urandom_range(0, 3) == 0
			? $urandom_range(0, 131071) : (64'd1 << $urandom_range(0, 16)));
		write_reg(fotb_pkg::REG_DIRECT_SPAN, rand64() >> $urandom_range(0, 63));
		write_reg(fotb_pkg::REG_SINGLE_SPAN, $urandom_range(0, 7) == 0 ? 64'd0
			: rand64() >> $urandom_range(0, 63));
		write_reg(fotb_pkg::REG_DOUBLE_SPAN, $urandom_range(0, 7) == 0 ? 64'd0
			: rand64() >> $urandom_range(0, 63));
		write_reg(fotb_pkg::REG_TRIPLE_SPAN, rand64() >> $urandom_range(0, 63));
	endtask

	initial begin
		board = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_offset(64'd0);
		send_offset(64'd49151);
		send_offset(64'd49152);
		send_offset(64'd2146303);
		send_offset(64'd2146304);
		send_offset(64'd1075888128);
		send_offset(64'd1075888127);
		send_offset(64'd551831702016);
		send_offset(64'd551831702015);
		send_offset('1);
		drain();
		sink_on = 1;
		write_reg(fotb_pkg::REG_BLOCK_SIZE, 64'd0);
		write_reg(fotb_pkg::REG_DIRECT_SPAN, 64'd0);
		write_reg(fotb_pkg::REG_SINGLE_SPAN, 64'd0);
		write_reg(fotb_pkg::REG_DOUBLE_SPAN, 64'd0);
		write_reg(fotb_pkg::REG_TRIPLE_SPAN, '1);
		send_offset(64'd0);
		send_offset('1);
		send_offset(64'h0000_0001_0000_0000);
		drain();
		write_reg(fotb_pkg::REG_BLOCK_SIZE, 64'd131071);
		write_reg(fotb_pkg::REG_DIRECT_SPAN, '1);
		write_reg(fotb_pkg::REG_SINGLE_SPAN, '1);
		write_reg(fotb_pkg::REG_DOUBLE_SPAN, '1);
		send_offset('1);
		send_offset(64'hFFFF_FFFF_FFFF_FFFE);
		send_offset(64'h5555_5555_5555_5555);
		drain();
		write_reg(fotb_pkg::REG_BLOCK_SIZE, 64'd1);
		write_reg(fotb_pkg::REG_DIRECT_SPAN, 64'd10);
		write_reg(fotb_pkg::REG_SINGLE_SPAN, 64'd1);
		write_reg(fotb_pkg::REG_DOUBLE_SPAN, 64'd1);
		write_reg(fotb_pkg::REG_TRIPLE_SPAN, '1);
		send_offset(64'd5);
		send_offset(64'd10);
		send_offset(64'd11);
		send_offset(64'd12);
		send_offset('1);
		send_offset(64'hAAAA_AAAA_AAAA_AAAA);
		drain();
		for (int ph = 0; ph < 10; ph++) begin
			random_config();
			for (int i = 0; i < 50; i++) send_offset(pick_offset());
			drain();
		end
		if (board.errors == 0 && board.pending_maps.size() == 0)
			$display("file_offset_to_block_tier_index test passed");
		else
			$display("file_offset_to_block_tier_index test failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("file_offset_to_block_tier_index test failed");
		$finish;
	end
endmodule
